>>> rtl/lcwtp_pkg.sv
// Shared types, widths and constants for the load-cell weigh, tare and presence block.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`timescale 1ns / 1ps

package lcwtp_pkg;

  // Block dimensions.
  localparam int SENSORS      = 6;
  localparam int TARE_AVERAGE = 5;
  localparam int TARE_DISCARD = 2;
  localparam int TARE_TOTAL   = TARE_DISCARD + TARE_AVERAGE;

  // Field widths fixed by the item formats.
  localparam int RAW_W      = 24;
  localparam int SENSOR_W   = 3;
  localparam int WEIGHT_W   = RAW_W + 1;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W    = 16;

  // Derived widths.
  localparam int NUM_CFG    = 2 + SENSORS;
  localparam int CFG_IDX_W  = $clog2(NUM_CFG);
  localparam int SENS_IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int TCNT_W     = $clog2(TARE_TOTAL + 1);
  localparam int SUM_W      = RAW_W + $clog2(TARE_AVERAGE);
  localparam int DIV_W      = (SUM_W > WEIGHT_W) ? SUM_W : WEIGHT_W;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int CMP_W      = WEIGHT_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BASE = CFG_IDX_W'(2);

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST  = CFG_DATA_W'(20);
  localparam logic [CFG_DATA_W-1:0] HYSTERESIS_RST = CFG_DATA_W'(5);
  localparam logic [SCALE_W-1:0]    SCALE_RST      = SCALE_W'(1);

  // Operation and status codes.
  typedef enum logic {
    OP_WEIGH = 1'b0,
    OP_TARE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_SENSOR = 2'd1,
    STAT_ZERO_SCALE = 2'd2
  } status_e;

  // Input and result transactions.
  typedef struct packed {
    op_e                 operation;
    logic [SENSOR_W-1:0] sensor;
    logic [RAW_W-1:0]    raw_code;
    logic                end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [SENSORS-1:0]         presence;
    logic                       presence_changed;
    logic                       tare_done;
    status_e                    status;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

>>> rtl/lcwtp_ctrl.sv
// Sequencing controller: input handshake, divider run and output register handshake.
// Depends on lcwtp_pkg; drives the commands of lcwtp_dp.
`timescale 1ns / 1ps

module lcwtp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  lcwtp_pkg::dp_status_t status_i,
  output lcwtp_pkg::dp_cmd_t    cmd_o
);
  import lcwtp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a result when empty or being emptied now.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = status_i.need_div ? ST_DIVIDE : ST_EMIT;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The result stays valid until the receiver takes it.
  assign out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/lcwtp_dp.sv
// Datapath: configuration registers, tare offsets and accumulator, serial divider,
// hysteresis presence logic and the result register.
// Depends on lcwtp_pkg; sequenced by lcwtp_ctrl.
`timescale 1ns / 1ps

module lcwtp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcwtp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcwtp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  lcwtp_pkg::in_item_t                 in_data_i,
  input  lcwtp_pkg::dp_cmd_t                  cmd_i,
  output lcwtp_pkg::dp_status_t               status_o,
  output lcwtp_pkg::out_item_t                out_data_o
);
  import lcwtp_pkg::*;

  localparam logic [SENSOR_W:0]  SENS_LIM      = (SENSOR_W + 1)'(SENSORS);
  localparam logic [CFG_IDX_W:0] CFG_SCALE_END = (CFG_IDX_W + 1)'(NUM_CFG);
  localparam logic [TCNT_W-1:0]  TCNT_DISCARD  = TCNT_W'(TARE_DISCARD);
  localparam logic [TCNT_W-1:0]  TCNT_TOTAL    = TCNT_W'(TARE_TOTAL);
  localparam logic [DCNT_W-1:0]  DCNT_LAST     = DCNT_W'(DIV_W - 1);

  // Configuration and persistent state.
  logic [CFG_DATA_W-1:0]   thr_q, hyst_q;
  logic [SCALE_W-1:0]      scale_q [SENSORS];
  logic [RAW_W-1:0]        offset_q [SENSORS];
  logic [TCNT_W-1:0]       tcnt_q;
  logic signed [SUM_W-1:0] tsum_q;
  logic [SENSOR_W-1:0]     tsensor_q;
  logic [SENSORS-1:0]      presence_q, reported_q;

  // Item in flight.
  in_item_t                item_q;
  logic                    valid_q, zero_q, complete_q;

  // Serial divider.
  logic [DIV_W-1:0]        dq_q;
  logic [SCALE_W-1:0]      rem_q, dvs_q;
  logic                    neg_q;
  logic [DCNT_W-1:0]       dcnt_q;

  // Result register.
  out_item_t               out_q;

  // ---------------------------------------------------------------------------
  // Decode of the incoming transaction.
  logic [CFG_IDX_W-1:0]    cfg_off;
  logic [SENS_IDX_W-1:0]   in_idx;
  logic                    in_valid_sensor;
  logic signed [RAW_W-1:0] code_s, off_s;
  logic signed [WEIGHT_W-1:0] diff;
  logic [WEIGHT_W-1:0]     diff_mag;
  logic [SCALE_W-1:0]      scale_sel;
  logic                    restart;
  logic [TCNT_W-1:0]       tcnt_base, tcnt_new;
  logic signed [SUM_W-1:0] tsum_base, tsum_new;
  logic [SUM_W-1:0]        tsum_mag;
  logic                    in_complete;

  assign cfg_off         = cfg_idx_i - CFG_SCALE_BASE;
  assign in_idx          = in_data_i.sensor[SENS_IDX_W-1:0];
  assign in_valid_sensor = {1'b0, in_data_i.sensor} < SENS_LIM;
  assign code_s          = in_data_i.raw_code;
  assign off_s           = offset_q[in_idx];
  assign scale_sel       = scale_q[in_idx];

  // Weigh path: offset-corrected code and its magnitude.
  assign diff     = WEIGHT_W'(code_s) - WEIGHT_W'(off_s);
  assign diff_mag = diff[WEIGHT_W-1] ? (~diff + 1'b1) : diff;

  // Tare path: restart on a new sensor, skip the first samples, then accumulate.
  assign restart   = (tcnt_q == '0) || (tsensor_q != in_data_i.sensor);
  assign tcnt_base = restart ? '0 : tcnt_q;
  assign tsum_base = restart ? '0 : tsum_q;
  assign tsum_new  = (tcnt_base >= TCNT_DISCARD) ? (tsum_base + SUM_W'(code_s)) : tsum_base;
  assign tcnt_new  = tcnt_base + 1'b1;
  assign in_complete = tcnt_new >= TCNT_TOTAL;
  assign tsum_mag  = tsum_new[SUM_W-1] ? (~tsum_new + 1'b1) : tsum_new;

  // ---------------------------------------------------------------------------
  // Divider step: shift in one dividend bit, subtract when it fits.
  logic [SCALE_W:0] rem_sh, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign status_o.need_div = valid_q && ((item_q.operation == OP_TARE) ? complete_q : !zero_q);
  assign status_o.div_last = dcnt_q == DCNT_LAST;

  // ---------------------------------------------------------------------------
  // Result of the item and the presence update.
  logic [SENS_IDX_W-1:0]      idx_q;
  logic [WEIGHT_W-1:0]        q_mag, q_signed;
  logic signed [WEIGHT_W-1:0] weight_c;
  logic                       weigh_ok, tare_ok;
  logic [CFG_DATA_W:0]        hi_u;
  logic signed [CFG_DATA_W+1:0] lo_s;
  logic signed [CMP_W-1:0]    w_cmp, hi_cmp, lo_cmp;
  logic [SENSORS-1:0]         pres_next;
  logic                       changed;
  status_e                    stat_c;

  assign idx_q    = item_q.sensor[SENS_IDX_W-1:0];
  assign q_mag    = dq_q[WEIGHT_W-1:0];
  assign q_signed = neg_q ? (~q_mag + 1'b1) : q_mag;
  assign weigh_ok = (item_q.operation == OP_WEIGH) && valid_q && !zero_q;
  assign tare_ok  = (item_q.operation == OP_TARE) && valid_q && complete_q;
  assign weight_c = weigh_ok ? q_signed : '0;

  // Hysteresis band, compared at full precision.
  assign hi_u   = {1'b0, thr_q} + {1'b0, hyst_q};
  assign lo_s   = {2'b00, thr_q} - {2'b00, hyst_q};
  assign w_cmp  = CMP_W'(weight_c);
  assign hi_cmp = CMP_W'(hi_u);
  assign lo_cmp = CMP_W'(lo_s);

  always_comb begin
    pres_next = presence_q;
    if (weigh_ok) begin
      if (w_cmp > hi_cmp) begin
        pres_next[idx_q] = 1'b1;
      end else if (w_cmp < lo_cmp) begin
        pres_next[idx_q] = 1'b0;
      end
    end
  end

  assign changed = (item_q.operation == OP_WEIGH) && item_q.end_of_scan &&
                   (pres_next != reported_q);

  always_comb begin
    if (!valid_q) begin
      stat_c = STAT_BAD_SENSOR;
    end else if ((item_q.operation == OP_WEIGH) && zero_q) begin
      stat_c = STAT_ZERO_SCALE;
    end else begin
      stat_c = STAT_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers, tare offsets and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESHOLD_RST;
      hyst_q     <= HYSTERESIS_RST;
      for (int i = 0; i < SENSORS; i++) begin
        scale_q[i]  <= SCALE_RST;
        offset_q[i] <= '0;
      end
      tcnt_q     <= '0;
      tsum_q     <= '0;
      tsensor_q  <= '0;
      presence_q <= '0;
      reported_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_THRESHOLD) begin
          thr_q <= cfg_wdata_i;
        end else if (cfg_idx_i == CFG_HYSTERESIS) begin
          hyst_q <= cfg_wdata_i;
        end else if ((cfg_idx_i >= CFG_SCALE_BASE) && ({1'b0, cfg_idx_i} < CFG_SCALE_END)) begin
          scale_q[cfg_off[SENS_IDX_W-1:0]] <= cfg_wdata_i;
        end
      end
      // Tare sequence advances as the tare transaction is taken.
      if (cmd_i.accept && (in_data_i.operation == OP_TARE) && in_valid_sensor) begin
        tsensor_q <= in_data_i.sensor;
        tcnt_q    <= in_complete ? '0 : tcnt_new;
        tsum_q    <= in_complete ? '0 : tsum_new;
      end
      // Presence, reported bitmap and new offset commit with the result.
      if (cmd_i.emit) begin
        presence_q <= pres_next;
        if (changed) begin
          reported_q <= pres_next;
        end
        if (tare_ok) begin
          offset_q[idx_q] <= q_signed[RAW_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture, divider and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q     <= in_data_i;
      valid_q    <= in_valid_sensor;
      zero_q     <= scale_sel == '0;
      complete_q <= in_complete;
      rem_q      <= '0;
      dcnt_q     <= '0;
      if (in_data_i.operation == OP_TARE) begin
        dq_q  <= DIV_W'(tsum_mag);
        dvs_q <= SCALE_W'(TARE_AVERAGE);
        neg_q <= tsum_new[SUM_W-1];
      end else begin
        dq_q  <= DIV_W'(diff_mag);
        dvs_q <= scale_sel;
        neg_q <= diff[WEIGHT_W-1];
      end
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
      dq_q   <= {dq_q[DIV_W-2:0], fits};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_q.weight           <= weight_c;
      out_q.presence         <= pres_next;
      out_q.presence_changed <= changed;
      out_q.tare_done        <= tare_ok;
      out_q.status           <= stat_c;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/load_cell_weigh_tare_presence.sv
// Top level of the load-cell weigh, tare and presence block.
// Depends on lcwtp_pkg; instantiates lcwtp_ctrl and lcwtp_dp.
`timescale 1ns / 1ps

// Usage:
// Input transactions (operation, sensor, raw_code, end_of_scan) are taken when
// in_valid_i is high and in_stall_o is low. Each produces exactly one result
// transaction (weight, presence, presence_changed, tare_done, status), offered
// on out_valid_o and taken when out_stall_i is low.
// The block works on one transaction at a time. A weigh transaction with a valid
// sensor and nonzero scale, and a tare transaction that completes an average, run
// the shared restoring divider, one quotient bit per cycle over DIV_W (27) bits;
// the next transaction can be taken once the result has entered the output
// register. All other transactions need no division and go from the check state
// straight to the emit state.
// A finished result sits in the output register. If the receiver stalls, the
// block still takes and works on one more transaction, then holds that result
// with in_stall_o high until the output register is freed.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i while the block is idle. Reset returns the registers to their
// defaults, clears all tare offsets, the tare sequence and the presence bitmaps,
// and leaves no result pending; the block takes input right after reset.

module load_cell_weigh_tare_presence (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lcwtp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcwtp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lcwtp_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lcwtp_pkg::out_item_t             out_data_o
);
  import lcwtp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // Sequencing of the handshakes and the divider.
  lcwtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Arithmetic, state and result register.
  lcwtp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/lcwtp_chk.sv
// Port-level checker for the load-cell weigh, tare and presence block.
// Depends on lcwtp_pkg; bound to load_cell_weigh_tare_presence.
`timescale 1ns / 1ps

module lcwtp_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input lcwtp_pkg::out_item_t             out_data_o
);
  import lcwtp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only one transaction is in work: acceptance closes the input side.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in work");

  // Errored transactions report zero grams.
  a_err_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_OK) |-> (out_data_o.weight == '0))
    else $error("nonzero weight on an error status");

  // A completed tare is never flagged as a presence change, never an error and reports zero weight.
  a_tare_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tare_done |->
      !out_data_o.presence_changed && (out_data_o.status == STAT_OK) &&
      (out_data_o.weight == '0))
    else $error("inconsistent tare completion result");

endmodule

bind load_cell_weigh_tare_presence lcwtp_chk u_lcwtp_chk (.*);
